@@ design/hexled_pkg.sv @@
package hexled_pkg;

    localparam int ROWS       = 8;
    localparam int MAX_DIGITS = 16;
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COUNT_W    = $clog2(MAX_DIGITS + 1);

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } t_in;

    typedef struct packed {
        logic [ROW_W-1:0]   row_index;
        logic [7:0]         row_bits;
        logic               last_row;
        logic [COUNT_W-1:0] digits_used;
    } t_out;

    typedef struct packed {
        logic       valid;
        logic [3:0] value;
    } t_nibble;

    // ASCII hex digit to nibble; valid clear for anything else
    function automatic t_nibble hex_decode(input logic [7:0] ch);
        t_nibble res;
        res.valid = 1'b0;
        res.value = 4'd0;
        if (ch >= 8'h30 && ch <= 8'h39) begin
            res.valid = 1'b1;
            res.value = 4'(ch - 8'h30);
        end else if (ch >= 8'h61 && ch <= 8'h66) begin
            res.valid = 1'b1;
            res.value = 4'(ch - 8'h61 + 8'd10);
        end else if (ch >= 8'h41 && ch <= 8'h46) begin
            res.valid = 1'b1;
            res.value = 4'(ch - 8'h41 + 8'd10);
        end
        return res;
    endfunction

endpackage

@@ design/hex_text_to_led_matrix_bitmap_top.sv @@
// Hex text to 8x8 LED bitmap. Characters enter one per cycle on start while
// busy is low. Each hex digit (either case) sets up to four pixels. The first
// non-hex character stops decoding, and digits past the sixteenth are dropped.
// A character with end_of_text set is decoded first. The bitmap is then copied
// out and the store is cleared in that same cycle. The 8 rows follow on
// o_strobe, one per cycle, starting the cycle after the end character. The
// receiver cannot stall, so take each beat as it comes. busy is high during
// rows 0..6 of an emission and holds off every character, since the single
// snapshot must drain first. No character is taken after an end character
// until the last row is on the output.
module hex_text_to_led_matrix_bitmap_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  hexled_pkg::t_in   i_in,
    output logic              busy,
    output logic              o_strobe,
    output hexled_pkg::t_out  o_result
);

    logic [7:0]                       r_rows [hexled_pkg::ROWS];
    logic [7:0]                       n_rows [hexled_pkg::ROWS];
    logic [hexled_pkg::COUNT_W-1:0]   r_count, n_count;
    logic                             r_stopped, n_stopped;

    logic [7:0]                       r_snap [hexled_pkg::ROWS];
    logic [hexled_pkg::COUNT_W-1:0]   r_digits;
    logic                             r_emit, n_emit;
    logic [hexled_pkg::ROW_W-1:0]     r_row, n_row;

    logic                             take;
    logic                             snap;
    hexled_pkg::t_nibble              nib;
    logic [2:0]                       col;
    logic [hexled_pkg::ROW_W-1:0]     base;
    logic [7:0]                       upd_rows [hexled_pkg::ROWS];
    logic [hexled_pkg::COUNT_W-1:0]   upd_count;
    logic                             upd_stopped;

    assign take = start && !busy;
    assign snap = take && i_in.end_of_text;
    assign nib  = hexled_pkg::hex_decode(i_in.char_code);
    assign col  = r_count[3:1];
    assign base = r_count[0] ? hexled_pkg::ROW_W'(4) : hexled_pkg::ROW_W'(0);

    always_comb begin
        upd_rows    = r_rows;
        upd_count   = r_count;
        upd_stopped = r_stopped;
        if (take && !r_stopped && r_count < hexled_pkg::COUNT_W'(hexled_pkg::MAX_DIGITS)) begin
            if (!nib.valid) begin
                upd_stopped = 1'b1;
            end else begin
                // nibble bit j lands in row base+3-j, column = byte index
                for (int j = 0; j < 4; j++) begin
                    if (nib.value[j]) begin
                        upd_rows[base + hexled_pkg::ROW_W'(3 - j)][col] = 1'b1;
                    end
                end
                upd_count = r_count + 1'b1;
            end
        end
    end

    always_comb begin
        n_rows    = upd_rows;
        n_count   = upd_count;
        n_stopped = upd_stopped;
        n_emit    = r_emit;
        n_row     = r_row;
        if (r_emit) begin
            n_row = r_row + 1'b1;
            if (r_row == hexled_pkg::ROW_W'(hexled_pkg::ROWS - 1)) begin
                n_emit = 1'b0;
            end
        end
        if (snap) begin
            // clear the store for the next text; start row 0 next cycle
            for (int r = 0; r < hexled_pkg::ROWS; r++) begin
                n_rows[r] = 8'd0;
            end
            n_count   = '0;
            n_stopped = 1'b0;
            n_emit    = 1'b1;
            n_row     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < hexled_pkg::ROWS; r++) begin
                r_rows[r] <= 8'd0;
            end
            r_count   <= '0;
            r_stopped <= 1'b0;
            r_emit    <= 1'b0;
            r_row     <= '0;
        end else begin
            r_rows    <= n_rows;
            r_count   <= n_count;
            r_stopped <= n_stopped;
            r_emit    <= n_emit;
            r_row     <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snap) begin
            r_snap   <= upd_rows;
            r_digits <= upd_count;
        end
    end

    assign busy                 = r_emit && (r_row != hexled_pkg::ROW_W'(hexled_pkg::ROWS - 1));
    assign o_strobe             = r_emit;
    assign o_result.row_index   = r_row;
    assign o_result.row_bits    = r_snap[r_row];
    assign o_result.last_row    = r_emit && (r_row == hexled_pkg::ROW_W'(hexled_pkg::ROWS - 1));
    assign o_result.digits_used = r_digits;

`ifndef SYNTHESIS
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_result.last_row) |=>
            (o_strobe && o_result.row_index == $past(o_result.row_index) + 1'b1))
        else $error("emission skipped or dropped a row");

    a_end_starts_rows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        snap |=> (o_strobe && o_result.row_index == '0))
        else $error("end of text did not start row 0");

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= hexled_pkg::COUNT_W'(hexled_pkg::MAX_DIGITS))
        else $error("digit count past limit");

    a_stopped_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_in.end_of_text && (r_stopped ||
            r_count == hexled_pkg::COUNT_W'(hexled_pkg::MAX_DIGITS))) |=>
            ($stable(r_count) && r_rows[0] == $past(r_rows[0])
                && r_rows[7] == $past(r_rows[7])))
        else $error("bitmap changed after decode stopped");
`endif

endmodule

@@ dv/hex_text_to_led_matrix_bitmap_top_tb.sv @@
module hex_text_to_led_matrix_bitmap_top_tb;

    localparam int IDLE_LIMIT   = 2000;
    localparam int RANDOM_CHARS = 300;

    class bitmap_scoreboard;
        logic [7:0]                     rows [hexled_pkg::ROWS];
        logic [hexled_pkg::COUNT_W-1:0] count;
        bit                             stopped;
        hexled_pkg::t_out               expected_rows [$];
        int                             errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            foreach (rows[r]) rows[r] = 8'h00;
            count   = '0;
            stopped = 1'b0;
        endfunction

        function int pending();
            return expected_rows.size();
        endfunction

        // returns 16 for anything that is not a hex digit
        function int nibble_of(logic [7:0] ch);
            if (ch >= "0" && ch <= "9") return int'(ch) - int'("0");
            if (ch >= "a" && ch <= "f") return int'(ch) - int'("a") + 10;
            if (ch >= "A" && ch <= "F") return int'(ch) - int'("A") + 10;
            return 16;
        endfunction

        function void note_char(hexled_pkg::t_in beat);
            int               v;
            int               col;
            int               base;
            hexled_pkg::t_out row;
            if (!stopped && count < hexled_pkg::MAX_DIGITS) begin
                v = nibble_of(beat.char_code);
                if (v > 15) begin
                    stopped = 1'b1;
                end else begin
                    col  = int'(count) / 2;
                    base = count[0] ? 4 : 0;
                    // high nibble lands in rows 0..3, low nibble in rows 4..7
                    for (int j = 0; j < 4; j++)
                        if (v[j]) rows[base + 3 - j][col] = 1'b1;
                    count = count + 1'b1;
                end
            end
            if (beat.end_of_text) begin
                for (int r = 0; r < hexled_pkg::ROWS; r++) begin
                    row.row_index   = hexled_pkg::ROW_W'(r);
                    row.row_bits    = rows[r];
                    row.last_row    = (r == hexled_pkg::ROWS - 1);
                    row.digits_used = count;
                    expected_rows.push_back(row);
                end
                clear();
            end
        endfunction

        function void check_row(hexled_pkg::t_out got);
            hexled_pkg::t_out want;
            if (expected_rows.size() == 0) begin
                $error("row %0d arrived with no row pending", got.row_index);
                errors++;
                return;
            end
            want = expected_rows.pop_front();
            if (got.row_index !== want.row_index) begin
                $error("row_index: expected %0d, got %0d", want.row_index, got.row_index);
                errors++;
            end
            if (got.row_bits !== want.row_bits) begin
                $error("row_bits: expected %h, got %h", want.row_bits, got.row_bits);
                errors++;
            end
            if (got.last_row !== want.last_row) begin
                $error("last_row: expected %b, got %b", want.last_row, got.last_row);
                errors++;
            end
            if (got.digits_used !== want.digits_used) begin
                $error("digits_used: expected %0d, got %0d",
                       want.digits_used, got.digits_used);
                errors++;
            end
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    hexled_pkg::t_in    i_in;
    logic               busy;
    logic               o_strobe;
    hexled_pkg::t_out   o_result;

    bitmap_scoreboard sb;
    int     chars_sent;
    int     idle_cycles;

    hex_text_to_led_matrix_bitmap_top dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_in     (i_in),
        .busy     (busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe) sb.check_row(o_result);
    end

    // count cycles in which no beat moves either way
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("hex_text_to_led_matrix_bitmap_top test failed");
                $finish;
            end
        end
    end

    task automatic send_char(input logic [7:0] ch, input bit last, input int gap);
        hexled_pkg::t_in beat;
        beat.char_code   = ch;
        beat.end_of_text = last;
        repeat (gap) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start = 1'b1;
        i_in  = beat;
        // hold until the block takes the beat
        do @(posedge i_clk); while (busy);
        sb.note_char(beat);
        chars_sent++;
    endtask

    task automatic send_text(input string text, input bit terminate);
        for (int i = 0; i < text.len(); i++)
            send_char(text[i], terminate && (i == text.len() - 1), 0);
    endtask

    function automatic logic [7:0] random_digit();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) return 8'("0" + v);
        return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
    endfunction

    task automatic send_random_text();
        int          len;
        int          bad_at;
        bit          burst;
        logic [7:0]  ch;
        len    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 22) : $urandom_range(1, 18);
        bad_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, len - 1) : -1;
        burst  = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++) begin
            if (i == bad_at || $urandom_range(0, 19) == 0)
                ch = 8'($urandom_range(0, 255));
            else
                ch = random_digit();
            send_char(ch, i == len - 1, burst ? 0 : $urandom_range(0, 11));
        end
    endtask

    initial begin
        sb          = new();
        chars_sent  = 0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_in        = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // full sixteen digits in mixed case, then a seventeenth that is dropped
        send_text("AbCdEf0123456789", 1'b0);
        send_char("5", 1'b1, 0);
        // a non-hex character stops decoding for the rest of the text
        send_text("8g1", 1'b1);
        // all-invalid text ends at once, back to back with the next one
        send_char(8'hFF, 1'b1, 0);
        send_char(8'h00, 1'b1, 0);
        // a short text leaves the missing digits at zero
        send_text("F:0", 1'b1);

        while (chars_sent < RANDOM_CHARS)
            send_random_text();

        @(negedge i_clk);
        start = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("hex_text_to_led_matrix_bitmap_top test passed");
        else
            $display("hex_text_to_led_matrix_bitmap_top test failed");
        $finish;
    end

endmodule
